[design/base64_digest_decoder_unit_assert.svh]
// Assertion macros shared by the base64 digest decoder RTL.
`ifndef BASE64_DIGEST_DECODER_UNIT_ASSERT_SVH
`define BASE64_DIGEST_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define B64DD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define B64DD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/b64dd_pkg.sv]
// Types, constants and the character decode function of the base64 digest decoder.
package b64dd_pkg;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_LENGTH    = 3'd1,
		ERR_SHORT     = 3'd2,
		ERR_BADCHAR   = 3'd3,
		ERR_AFTERPAD  = 3'd4,
		ERR_OVERFLOW  = 3'd5,
		ERR_UNDERFLOW = 3'd6
	} err_t;

	localparam logic [7:0] CH_PAD    = 8'h3D; // '='
	localparam logic [6:0] DIGIT_BAD = 7'd64;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       end_of_token;
		logic       decode_ok;
		err_t       error_code;
	} result_t;

	// Both alphabets: '+'/'-' give 62, '/'/'_' give 63, anything else DIGIT_BAD.
	function automatic logic [6:0] digit_value(input logic [7:0] c);
		logic [6:0] v;
		v = DIGIT_BAD;
		if (c inside {[8'h41:8'h5A]}) begin
			v = 7'(c - 8'h41);
		end else if (c inside {[8'h61:8'h7A]}) begin
			v = 7'(c - 8'h61 + 8'd26);
		end else if (c inside {[8'h30:8'h39]}) begin
			v = 7'(c - 8'h30 + 8'd52);
		end else if (c inside {8'h2B, 8'h2D}) begin
			v = 7'd62;
		end else if (c inside {8'h2F, 8'h5F}) begin
			v = 7'd63;
		end
		return v;
	endfunction

endpackage

[design/base64_digest_decoder_unit.sv]
// Streaming base64 digest decoder: one token character per item, up to three bytes out.
// The block takes one character per clock when ready: an input register feeds a single
// stage of decode logic that updates the group state and writes 0 to 3 results into a
// 4-entry result queue, which drains one result per cycle while out_ready is high. A
// character is taken whenever the queue has room for the results it produces, so at one
// result per cycle on the output side the sustained rate is one character per cycle (a
// complete group of four characters yields at most three bytes). The status of a token
// travels on its last result. expected_bytes must be written through cfg_we/cfg_wdata only
// while idle (not enforced by the block); values above MAX_DIGEST_BYTES are clamped to it.
`include "base64_digest_decoder_unit_assert.svh"

module base64_digest_decoder_unit
	import b64dd_pkg::*;
#(
	parameter int MAX_DIGEST_BYTES = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [6:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] character,
	input  logic       no_char,
	input  logic       final_char,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       end_of_token,
	output logic       decode_ok,
	output logic [2:0] error_code
);

	localparam int BW        = $clog2(MAX_DIGEST_BYTES + 1);
	localparam int LIMIT_MAX = ((MAX_DIGEST_BYTES + 2) / 3) * 4;
	localparam int CW        = $clog2(LIMIT_MAX + 1);
	localparam int CMPW      = (BW > 7) ? BW : 7;
	localparam int RST_E     = (MAX_DIGEST_BYTES < 32) ? MAX_DIGEST_BYTES : 32;
	localparam int RST_LIMIT = ((RST_E + 2) / 3) * 4;
	localparam int DEPTH     = 4;

	// configuration: effective byte count and character limit
	logic [BW-1:0]   e_q;
	logic [CW-1:0]   limit_q;
	logic [CMPW-1:0] wd_ext;
	logic [CMPW-1:0] e_new;
	logic [15:0]     quot_prod;

	assign wd_ext    = CMPW'(cfg_wdata);
	assign e_new     = (wd_ext > CMPW'(MAX_DIGEST_BYTES)) ? CMPW'(MAX_DIGEST_BYTES) : wd_ext;
	// (e + 2) / 3 by reciprocal 171/512, exact for e + 2 below 512
	assign quot_prod = (16'(e_new) + 16'd2) * 16'd171;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_q     <= BW'(RST_E);
			limit_q <= CW'(RST_LIMIT);
		end else if (cfg_we) begin
			e_q     <= BW'(e_new);
			limit_q <= CW'({quot_prod[15:9], 2'b00});
		end
	end

	// input register
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       nochar_s1;
	logic       final_s1;
	logic       fire;

	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1   <= character;
			nochar_s1 <= no_char;
			final_s1  <= final_char;
		end
	end

	// token state
	logic [23:0]   gb_q;
	logic [1:0]    slot_q;
	logic [1:0]    pad_q;
	logic [CW-1:0] cc_q;
	logic [BW-1:0] bc_q;
	err_t          err_q;

	// decode logic
	logic          fin;
	logic [6:0]    dv;
	logic [23:0]   gb_c;
	logic [1:0]    slot_c;
	logic [1:0]    pad_c;
	logic [CW-1:0] cc_c;
	err_t          err_c;
	logic          done_c;
	logic [23:0]   gb_f;
	logic [1:0]    pad_f;
	err_t          err_f;
	err_t          err_end;
	logic          do_finish;
	logic [1:0]    produced;
	logic [BW:0]   bsum;
	logic          ovf;
	logic [1:0]    nbytes;
	logic [BW-1:0] bc_n;
	logic [1:0]    k_res;
	result_t       res [3];

	always_comb begin
		fin    = final_s1 | nochar_s1;
		dv     = digit_value(char_s1);
		gb_c   = gb_q;
		slot_c = slot_q;
		pad_c  = pad_q;
		cc_c   = cc_q;
		err_c  = err_q;
		done_c = 1'b0;
		if (!nochar_s1 && err_q == ERR_NONE) begin
			if (cc_q >= limit_q) begin
				err_c = ERR_LENGTH;
			end else begin
				cc_c = cc_q + CW'(1);
				if (slot_q == 2'd0 && pad_q != 2'd0) begin
					err_c = ERR_AFTERPAD;
				end else if (char_s1 == CH_PAD) begin
					if (slot_q < 2'd2) begin
						err_c = ERR_SHORT;
					end else begin
						gb_c   = {gb_q[17:0], 6'd0};
						pad_c  = pad_q + 2'd1;
						slot_c = slot_q + 2'd1;
						done_c = (slot_q == 2'd3);
					end
				end else if (pad_q != 2'd0) begin
					err_c = ERR_AFTERPAD;
				end else if (dv[6]) begin
					err_c = ERR_BADCHAR;
				end else begin
					gb_c   = {gb_q[17:0], dv[5:0]};
					slot_c = slot_q + 2'd1;
					done_c = (slot_q == 2'd3);
				end
			end
		end

		// end of token: implied padding closes a partial group
		gb_f      = gb_c;
		pad_f     = pad_c;
		err_f     = err_c;
		do_finish = done_c;
		if (fin && err_c == ERR_NONE) begin
			if (cc_c == '0) begin
				err_f = ERR_LENGTH;
			end else if (slot_c == 2'd1) begin
				err_f = ERR_SHORT;
			end else if (slot_c == 2'd2) begin
				gb_f      = {gb_c[11:0], 12'd0};
				pad_f     = pad_c + 2'd2;
				do_finish = 1'b1;
			end else if (slot_c == 2'd3) begin
				gb_f      = {gb_c[17:0], 6'd0};
				pad_f     = pad_c + 2'd1;
				do_finish = 1'b1;
			end
		end

		produced = 2'd3 - pad_f;
		bsum     = {1'b0, bc_q} + (BW+1)'(produced);
		ovf      = do_finish && (bsum > {1'b0, e_q});
		if (ovf) begin
			err_f = ERR_OVERFLOW;
		end
		nbytes  = (do_finish && !ovf) ? produced : 2'd0;
		bc_n    = (do_finish && !ovf) ? bsum[BW-1:0] : bc_q;
		err_end = (err_f == ERR_NONE && bc_n != e_q) ? ERR_UNDERFLOW : err_f;
		k_res   = (fin && nbytes == 2'd0) ? 2'd1 : nbytes;

		// status rides on the last result of a final item
		for (int i = 0; i < 3; i++) begin
			res[i].byte_valid   = (2'(i) < nbytes);
			res[i].out_byte     = (2'(i) < nbytes) ? gb_f[23-8*i -: 8] : 8'd0;
			res[i].end_of_token = fin && (2'(i) == k_res - 2'd1);
			res[i].decode_ok    = res[i].end_of_token && (err_end == ERR_NONE);
			res[i].error_code   = res[i].end_of_token ? err_end : ERR_NONE;
		end
	end

	// result queue
	result_t    fifo_q [DEPTH];
	logic [1:0] wptr_q;
	logic [1:0] rptr_q;
	logic [2:0] cnt_q;
	logic [2:0] free;
	logic       pop;
	result_t    head;

	assign free = 3'(DEPTH) - cnt_q;
	assign fire = valid_s1 && ({1'b0, k_res} <= free);
	assign pop  = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gb_q   <= '0;
			slot_q <= '0;
			pad_q  <= '0;
			cc_q   <= '0;
			bc_q   <= '0;
			err_q  <= ERR_NONE;
		end else if (fire) begin
			if (fin) begin
				gb_q   <= '0;
				slot_q <= '0;
				pad_q  <= '0;
				cc_q   <= '0;
				bc_q   <= '0;
				err_q  <= ERR_NONE;
			end else begin
				gb_q   <= do_finish ? 24'd0 : gb_c;
				slot_q <= slot_c;
				pad_q  <= pad_c;
				cc_q   <= cc_c;
				bc_q   <= bc_n;
				err_q  <= err_f;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (fire) begin
				wptr_q <= wptr_q + k_res;
			end
			if (pop) begin
				rptr_q <= rptr_q + 2'd1;
			end
			cnt_q <= cnt_q + (fire ? {1'b0, k_res} : 3'd0) - {2'b00, pop};
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (fire && 2'(i) < k_res) begin
				fifo_q[wptr_q + 2'(i)] <= res[i];
			end
		end
	end

	assign head         = fifo_q[rptr_q];
	assign out_valid    = (cnt_q != 3'd0);
	assign out_byte     = head.out_byte;
	assign byte_valid   = head.byte_valid;
	assign end_of_token = head.end_of_token;
	assign decode_ok    = head.decode_ok;
	assign error_code   = head.error_code;

	`B64DD_ASSERT_NOW(a_queue_bound, 1'b1, cnt_q <= 3'(DEPTH), "result queue overrun")
	`B64DD_ASSERT_NEXT(a_token_clear, fire && fin, slot_q == 2'd0 && bc_q == '0 && err_q == ERR_NONE, "token state not cleared after final item")
	`B64DD_ASSERT_NOW(a_ok_status, out_valid && decode_ok, end_of_token && error_code == ERR_NONE, "decode_ok without clean end of token")

endmodule
